// File: design/bhtb_pkg.sv
// Shared types, codes and defaults for the bucketed hash table engine.
package bhtb_pkg;

  localparam int DEF_CAPACITY        = 1024;
  localparam int DEF_MAX_BUCKET_BITS = 10;
  localparam int DEF_KEY_BITS        = 32;
  localparam int DEF_VALUE_BITS      = 32;

  localparam int HASH_BITS   = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int BITS_REG_W  = 4;
  localparam int LIMIT_REG_W = 11;

  localparam logic [HASH_BITS-1:0]   RST_MULT  = 32'd2654435769;
  localparam logic [BITS_REG_W-1:0]  RST_BITS  = 4'd10;
  localparam logic [LIMIT_REG_W-1:0] RST_LIMIT = 11'd4;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_BUILD  = 2'd1;
  localparam cmd_t CMD_LOOKUP = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_MISS     = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MULT  = 2'd0;
  localparam cfg_idx_t CFG_BITS  = 2'd1;
  localparam cfg_idx_t CFG_LIMIT = 2'd2;

endpackage

// File: design/bhtb_hash.sv
// Multiplicative hash unit: registered 32x32 product, top bits selected after.
module bhtb_hash #(
  parameter int MAX_BUCKET_BITS = bhtb_pkg::DEF_MAX_BUCKET_BITS,
  parameter int BB_W            = $clog2(MAX_BUCKET_BITS + 1)
) (
  input  logic                          clk,
  input  logic [bhtb_pkg::HASH_BITS-1:0] key_lo,
  input  logic [bhtb_pkg::HASH_BITS-1:0] mult,
  input  logic [BB_W-1:0]               bits,
  output logic [MAX_BUCKET_BITS-1:0]    hash
);
  import bhtb_pkg::*;

  logic [HASH_BITS-1:0] prod_r;
  logic [5:0]           shamt;

  always_ff @(posedge clk) begin
    prod_r <= HASH_BITS'(mult * key_lo);
  end

  assign shamt = 6'd32 - 6'(bits);
  assign hash  = MAX_BUCKET_BITS'(prod_r >> shamt);

endmodule

// File: design/bucketed_hash_table_build_lookup.sv
// Top level of the bucketed hash table engine: staging, build sequencer and lookup.
// One transaction in, one result out. Entries go to a staging memory; a build
// clears the bucket counters, counts the staged keys, forms prefix sums and
// scatters the entries into the table, unless a bucket count reaches the limit,
// which ends the build with an overflow status. A lookup hashes the key, reads
// the bucket start and scans table entries until a match, the table end or an
// entry of another hash. All work is sequenced through single-port-read memories
// with registered reads and a shared registered multiplier, one transaction at a
// time. Results sit in an output register; while it holds an untaken result, the sequencer waits.
module bucketed_hash_table_build_lookup #(
  parameter int CAPACITY        = bhtb_pkg::DEF_CAPACITY,
  parameter int MAX_BUCKET_BITS = bhtb_pkg::DEF_MAX_BUCKET_BITS,
  parameter int KEY_BITS        = bhtb_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS      = bhtb_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bhtb_pkg::cmd_t                 in_cmd,
  input  logic [KEY_BITS-1:0]            in_key,
  input  logic [VALUE_BITS-1:0]          in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bhtb_pkg::status_t              out_status,
  output logic                           out_found,
  output logic [VALUE_BITS-1:0]          out_result_value,
  input  logic                           cfg_we,
  input  bhtb_pkg::cfg_idx_t             cfg_index,
  input  logic [bhtb_pkg::CFG_W-1:0]     cfg_wdata
);
  import bhtb_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int HW   = MAX_BUCKET_BITS;
  localparam int NB   = 2 ** MAX_BUCKET_BITS;
  localparam int BIW  = MAX_BUCKET_BITS + 1;
  localparam int BB_W = $clog2(MAX_BUCKET_BITS + 1);
  localparam int EW   = KEY_BITS + VALUE_BITS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_CNT_RD   = 5'd2;
  localparam logic [4:0] S_CNT_MUL  = 5'd3;
  localparam logic [4:0] S_CNT_HASH = 5'd4;
  localparam logic [4:0] S_CNT_UPD  = 5'd5;
  localparam logic [4:0] S_PFX_RD   = 5'd6;
  localparam logic [4:0] S_PFX_WR   = 5'd7;
  localparam logic [4:0] S_SC_RD    = 5'd8;
  localparam logic [4:0] S_SC_MUL   = 5'd9;
  localparam logic [4:0] S_SC_HASH  = 5'd10;
  localparam logic [4:0] S_SC_UPD   = 5'd11;
  localparam logic [4:0] S_LK_MUL   = 5'd12;
  localparam logic [4:0] S_LK_HASH  = 5'd13;
  localparam logic [4:0] S_LK_START = 5'd14;
  localparam logic [4:0] S_LK_RD    = 5'd15;
  localparam logic [4:0] S_LK_CMP   = 5'd16;
  localparam logic [4:0] S_LK_CHK   = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;

  // configuration
  logic [HASH_BITS-1:0]   mult_r;
  logic [BITS_REG_W-1:0]  bits_r;
  logic [LIMIT_REG_W-1:0] limit_r;
  logic [BB_W-1:0]        cur_bits;

  // control state
  logic [4:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        tcount_r, tcount_nxt;
  logic                 built_r, built_nxt;
  logic [HASH_BITS-1:0] bmult_r, bmult_nxt;
  logic [BB_W-1:0]      bbits_r, bbits_nxt;
  logic                 lookup_r, lookup_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [BIW-1:0]       bidx_r, bidx_nxt;
  logic [CW-1:0]        sum_r, sum_nxt;
  logic [HW-1:0]        h_r, h_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [EW-1:0]        sc_r, sc_nxt;
  logic [1:0]           fst_r, fst_nxt;
  logic                 ffound_r, ffound_nxt;
  logic [VALUE_BITS-1:0] fval_r, fval_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_found_r;
  logic [VALUE_BITS-1:0] out_value_r;

  // memories
  logic [EW-1:0] stage_mem [CAPACITY];
  logic [EW-1:0] table_mem [CAPACITY];
  logic [CW-1:0] bstart_mem [NB];
  logic [EW-1:0] stage_rd, table_rd;
  logic [CW-1:0] bstart_rd;

  logic          stage_we, stage_re, table_we, table_re, bs_we, bs_re;
  logic [AW-1:0] stage_waddr, stage_raddr, table_waddr, table_raddr;
  logic [EW-1:0] stage_wdata, table_wdata;
  logic [HW-1:0] bs_waddr, bs_raddr;
  logic [CW-1:0] bs_wdata;

  // hash unit
  logic [HASH_BITS-1:0] hk_lo, hmult;
  logic [BB_W-1:0]      hbits;
  logic [HW-1:0]        hash;

  logic          accept, fin_go;
  logic [BIW-1:0] nb_cur;
  logic [CW-1:0]  cnt_inc, slot;

  assign cur_bits = (bits_r == '0) ? BB_W'(1) :
                    (32'(bits_r) > 32'(MAX_BUCKET_BITS)) ? BB_W'(MAX_BUCKET_BITS) :
                    BB_W'(bits_r);
  assign nb_cur  = BIW'(1) << cur_bits;
  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign cnt_inc = bstart_rd + CW'(1);
  assign slot    = bstart_rd - CW'(1);

  always_comb begin
    hmult = lookup_r ? bmult_r : mult_r;
    hbits = lookup_r ? bbits_r : cur_bits;
    unique case (state_r)
      S_LK_MUL: hk_lo = HASH_BITS'(key_r);
      S_LK_CMP: hk_lo = HASH_BITS'(table_rd[EW-1 -: KEY_BITS]);
      default:  hk_lo = HASH_BITS'(stage_rd[EW-1 -: KEY_BITS]);
    endcase
  end

  bhtb_hash #(
    .MAX_BUCKET_BITS(MAX_BUCKET_BITS),
    .BB_W           (BB_W)
  ) u_hash (
    .clk   (clk),
    .key_lo(hk_lo),
    .mult  (hmult),
    .bits  (hbits),
    .hash  (hash)
  );

  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[stage_waddr] <= stage_wdata;
    if (stage_re) stage_rd <= stage_mem[stage_raddr];
  end

  always_ff @(posedge clk) begin
    if (table_we) table_mem[table_waddr] <= table_wdata;
    if (table_re) table_rd <= table_mem[table_raddr];
  end

  always_ff @(posedge clk) begin
    if (bs_we) bstart_mem[bs_waddr] <= bs_wdata;
    if (bs_re) bstart_rd <= bstart_mem[bs_raddr];
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    tcount_nxt = tcount_r;
    built_nxt  = built_r;
    bmult_nxt  = bmult_r;
    bbits_nxt  = bbits_r;
    lookup_nxt = lookup_r;
    idx_nxt    = idx_r;
    bidx_nxt   = bidx_r;
    sum_nxt    = sum_r;
    h_nxt      = h_r;
    key_nxt    = key_r;
    sc_nxt     = sc_r;
    fst_nxt    = fst_r;
    ffound_nxt = ffound_r;
    fval_nxt   = fval_r;

    stage_we    = 1'b0;
    stage_waddr = count_r[AW-1:0];
    stage_wdata = {in_key, in_value};
    stage_re    = 1'b0;
    stage_raddr = idx_r[AW-1:0];
    table_we    = 1'b0;
    table_waddr = slot[AW-1:0];
    table_wdata = sc_r;
    table_re    = 1'b0;
    table_raddr = idx_r[AW-1:0];
    bs_we       = 1'b0;
    bs_waddr    = h_r;
    bs_wdata    = '0;
    bs_re       = 1'b0;
    bs_raddr    = hash;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          fst_nxt    = ST_OK;
          ffound_nxt = 1'b0;
          fval_nxt   = '0;
          idx_nxt    = '0;
          bidx_nxt   = '0;
          sum_nxt    = '0;
          key_nxt    = in_key;
          state_nxt  = S_FIN;
          priority case (in_cmd)
            CMD_ADD: begin
              if (32'(count_r) < 32'(CAPACITY)) begin
                stage_we  = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                fst_nxt = ST_FULL;
              end
            end
            CMD_BUILD: begin
              lookup_nxt = 1'b0;
              state_nxt  = S_CLR;
            end
            CMD_LOOKUP: begin
              fst_nxt = ST_MISS;
              if (built_r) begin
                lookup_nxt = 1'b1;
                state_nxt  = S_LK_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        if (bidx_r == nb_cur) begin
          state_nxt = S_CNT_RD;
        end else begin
          bs_we    = 1'b1;
          bs_waddr = bidx_r[HW-1:0];
          bidx_nxt = bidx_r + BIW'(1);
        end
      end
      S_CNT_RD: begin
        if (idx_r == count_r) begin
          bidx_nxt  = '0;
          state_nxt = S_PFX_RD;
        end else begin
          stage_re  = 1'b1;
          state_nxt = S_CNT_MUL;
        end
      end
      S_CNT_MUL: state_nxt = S_CNT_HASH;
      S_CNT_HASH: begin
        bs_re     = 1'b1;
        h_nxt     = hash;
        state_nxt = S_CNT_UPD;
      end
      S_CNT_UPD: begin
        bs_we    = 1'b1;
        bs_wdata = cnt_inc;
        idx_nxt  = idx_r + CW'(1);
        if (32'(cnt_inc) == 32'(limit_r)) begin
          built_nxt = 1'b0;
          fst_nxt   = ST_OVERFLOW;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CNT_RD;
        end
      end
      S_PFX_RD: begin
        if (bidx_r == nb_cur) begin
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end else begin
          bs_re     = 1'b1;
          bs_raddr  = bidx_r[HW-1:0];
          state_nxt = S_PFX_WR;
        end
      end
      S_PFX_WR: begin
        sum_nxt   = sum_r + bstart_rd;
        bs_we     = 1'b1;
        bs_waddr  = bidx_r[HW-1:0];
        bs_wdata  = sum_r + bstart_rd;
        bidx_nxt  = bidx_r + BIW'(1);
        state_nxt = S_PFX_RD;
      end
      S_SC_RD: begin
        if (idx_r == count_r) begin
          tcount_nxt = count_r;
          bmult_nxt  = mult_r;
          bbits_nxt  = cur_bits;
          built_nxt  = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          stage_re  = 1'b1;
          state_nxt = S_SC_MUL;
        end
      end
      S_SC_MUL: begin
        sc_nxt    = stage_rd;
        state_nxt = S_SC_HASH;
      end
      S_SC_HASH: begin
        bs_re     = 1'b1;
        h_nxt     = hash;
        state_nxt = S_SC_UPD;
      end
      S_SC_UPD: begin
        bs_we     = 1'b1;
        bs_wdata  = slot;
        table_we  = 1'b1;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SC_RD;
      end
      S_LK_MUL: state_nxt = S_LK_HASH;
      S_LK_HASH: begin
        bs_re     = 1'b1;
        h_nxt     = hash;
        state_nxt = S_LK_START;
      end
      S_LK_START: begin
        idx_nxt   = bstart_rd;
        state_nxt = S_LK_RD;
      end
      S_LK_RD: begin
        if (idx_r >= tcount_r) begin
          state_nxt = S_FIN;
        end else begin
          table_re  = 1'b1;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (table_rd[EW-1 -: KEY_BITS] == key_r) begin
          fst_nxt    = ST_OK;
          ffound_nxt = 1'b1;
          fval_nxt   = table_rd[VALUE_BITS-1:0];
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        if (hash != h_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_LK_RD;
        end
      end
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tcount_r    <= '0;
      built_r     <= 1'b0;
      lookup_r    <= 1'b0;
      bmult_r     <= RST_MULT;
      bbits_r     <= BB_W'(MAX_BUCKET_BITS);
      mult_r      <= RST_MULT;
      bits_r      <= RST_BITS;
      limit_r     <= RST_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      tcount_r <= tcount_nxt;
      built_r  <= built_nxt;
      lookup_r <= lookup_nxt;
      bmult_r  <= bmult_nxt;
      bbits_r  <= bbits_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MULT:  mult_r  <= cfg_wdata;
          CFG_BITS:  bits_r  <= cfg_wdata[BITS_REG_W-1:0];
          CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_REG_W-1:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    bidx_r   <= bidx_nxt;
    sum_r    <= sum_nxt;
    h_r      <= h_nxt;
    key_r    <= key_nxt;
    sc_r     <= sc_nxt;
    fst_r    <= fst_nxt;
    ffound_r <= ffound_nxt;
    fval_r   <= fval_nxt;
    if (fin_go) begin
      out_status_r <= fst_r;
      out_found_r  <= ffound_r;
      out_value_r  <= fval_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;

endmodule

// File: dv/bucketed_hash_table_build_lookup_test.sv
// Testbench for the bucketed hash table engine: random add/build/lookup traffic, scoreboarded.
`timescale 1ns / 1ps

module bucketed_hash_table_build_lookup_test;
  import bhtb_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int MAXB       = DEF_MAX_BUCKET_BITS;
  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    status_t     status;
    logic        found;
    logic [31:0] value;
  } lookup_result_t;

  class hash_table_scoreboard;
    logic [31:0]    staged_key [CAP];
    logic [31:0]    staged_val [CAP];
    logic [31:0]    table_key [CAP];
    logic [31:0]    table_val [CAP];
    int unsigned    bucket_first [1 << MAXB];
    int unsigned    staged_n;
    int unsigned    table_n;
    bit             built;
    logic [31:0]    built_mult;
    int unsigned    built_bits;
    logic [31:0]    mult_reg;
    logic [3:0]     bits_reg;
    logic [10:0]    limit_reg;
    lookup_result_t expected_q [$];
    int             errors;

    function new();
      staged_n   = 0;
      table_n    = 0;
      built      = 0;
      mult_reg   = RST_MULT;
      bits_reg   = RST_BITS;
      limit_reg  = RST_LIMIT;
      built_mult = RST_MULT;
      built_bits = MAXB;
      errors     = 0;
    endfunction

    function int unsigned hash_key(logic [31:0] k, logic [31:0] m, int unsigned b);
      logic [31:0] prod;
      prod = k * m;
      return prod >> (32 - b);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CFG_MULT:  mult_reg = d;
        CFG_BITS:  bits_reg = d[3:0];
        CFG_LIMIT: limit_reg = d[10:0];
        default: ;
      endcase
    endfunction

    function status_t build_table();
      int unsigned cnt [1 << MAXB];
      int unsigned b, nb, h, sum, slot;
      b = bits_reg;
      if (b < 1) b = 1;
      if (b > MAXB) b = MAXB;
      nb = 1 << b;
      for (int i = 0; i < nb; i++) cnt[i] = 0;
      for (int i = 0; i < staged_n; i++) begin
        h = hash_key(staged_key[i], mult_reg, b);
        cnt[h]++;
        if (cnt[h] == limit_reg) begin
          built = 0;
          return ST_OVERFLOW;
        end
      end
      sum = 0;
      for (int i = 0; i < nb; i++) begin
        sum += cnt[i];
        bucket_first[i] = sum;
      end
      // scatter in arrival order from the top of each bucket down
      for (int i = 0; i < staged_n; i++) begin
        h = hash_key(staged_key[i], mult_reg, b);
        bucket_first[h]--;
        slot = bucket_first[h];
        table_key[slot] = staged_key[i];
        table_val[slot] = staged_val[i];
      end
      table_n    = staged_n;
      built_mult = mult_reg;
      built_bits = b;
      built      = 1;
      return ST_OK;
    endfunction

    function void note_input(cmd_t cmd, logic [31:0] key, logic [31:0] val);
      lookup_result_t r;
      int unsigned h, i;
      r.status = ST_OK;
      r.found  = 1'b0;
      r.value  = '0;
      case (cmd)
        CMD_ADD: begin
          if (staged_n < CAP) begin
            staged_key[staged_n] = key;
            staged_val[staged_n] = val;
            staged_n++;
          end else begin
            r.status = ST_FULL;
          end
        end
        CMD_BUILD: r.status = build_table();
        CMD_LOOKUP: begin
          r.status = ST_MISS;
          if (built) begin
            h = hash_key(key, built_mult, built_bits);
            i = bucket_first[h];
            while (i < table_n) begin
              if (table_key[i] == key) begin
                r.status = ST_OK;
                r.found  = 1'b1;
                r.value  = table_val[i];
                break;
              end
              if (hash_key(table_key[i], built_mult, built_bits) != h) break;
              i++;
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(status_t st, logic fnd, logic [31:0] v);
      lookup_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: status %0d", st);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (fnd !== r.found) begin
        $error("found: expected %0d, actual %0d", r.found, fnd);
        errors++;
      end
      if (v !== r.value) begin
        $error("result_value: expected %h, actual %h", r.value, v);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_t        in_cmd = CMD_ADD;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     out_status;
  logic        out_found;
  logic [31:0] out_result_value;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_MULT;
  logic [31:0] cfg_wdata = '0;

  hash_table_scoreboard sb = new();
  int burst_left = 5;
  int rx_cycle = 0;
  int idle_cycles = 0;

  bucketed_hash_table_build_lookup i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_key, .in_value,
    .out_valid, .out_ready, .out_status, .out_found, .out_result_value,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #4 clk = ~clk;

  // receiver: check on handshake, then pick next ready from a rotating stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_found, out_result_value);
    rx_cycle++;
    case ((rx_cycle / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= (rx_cycle % 8) == 0;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(cmd_t cmd, logic [31:0] key, logic [31:0] val);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, key, val);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] mult, logic [31:0] bits, logic [31:0] limit);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MULT;
    cfg_wdata <= mult;
    @(posedge clk);
    cfg_index <= CFG_BITS;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_MULT, mult);
    sb.set_reg(CFG_BITS, bits);
    sb.set_reg(CFG_LIMIT, limit);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (sb.staged_n > 0 && $urandom_range(0, 9) < 7)
      return sb.staged_key[$urandom_range(0, sb.staged_n - 1)];
    return $urandom();
  endfunction

  initial begin
    int r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-table behavior, extremes, duplicates, setting changes
    send(CMD_LOOKUP, 32'h1234_5678, '0);
    send(cmd_t'(2'd3), '1, '1);
    send(CMD_BUILD, '0, '0);
    send(CMD_LOOKUP, '0, '0);
    send(CMD_ADD, '0, '1);
    send(CMD_ADD, '1, '0);
    send(CMD_ADD, 32'hA5A5_5A5A, 32'h1111_1111);
    send(CMD_ADD, 32'hA5A5_5A5A, 32'h2222_2222);
    send(CMD_BUILD, '1, '1);
    send(CMD_LOOKUP, '0, '1);
    send(CMD_LOOKUP, '1, '0);
    send(CMD_LOOKUP, 32'hA5A5_5A5A, '0);
    send(CMD_LOOKUP, 32'h0000_0001, '0);
    configure(32'h0000_0003, 32'd0, 32'd0);
    send(CMD_LOOKUP, 32'hA5A5_5A5A, '0);
    send(CMD_ADD, 32'h8000_0000, 32'h8000_0001);
    send(CMD_BUILD, '0, '0);
    send(CMD_LOOKUP, 32'h8000_0000, '0);
    send(CMD_LOOKUP, '1, '0);
    configure(32'h0000_0005, 32'd15, 32'd1);
    send(CMD_BUILD, '0, '0);
    send(CMD_LOOKUP, '0, '0);
    configure(RST_MULT, 32'd10, 32'd2047);
    send(CMD_BUILD, '0, '0);
    send(CMD_LOOKUP, 32'h8000_0000, '0);

    // random phases: adds, occasional builds, mostly lookups of known keys
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(32'h0, 32'd1 + $urandom_range(0, 9), 32'd2047);
        1: configure(32'hFFFF_FFFF, 32'd10, 32'd0);
        2: configure($urandom() | 1, 32'd0, 32'd1024);
        3: configure($urandom() | 1, 32'd15, 32'd2047);
        4: configure($urandom() | 1, 32'd1, 32'd0);
        5: configure($urandom() | 1, 32'd10, 32'd2);
        6: configure($urandom(), $urandom_range(1, 10), 32'd1024);
        default: configure($urandom() | 1, $urandom_range(0, 15), $urandom_range(2, 30));
      endcase
      if (p == 3) drain();
      for (int k = 0; k < 90; k++) begin
        r = $urandom_range(0, 99);
        if (r < 35)
          send(CMD_ADD, ($urandom_range(0, 4) == 0) ? pick_key() : $urandom(), $urandom());
        else if (r < 40)
          send(CMD_BUILD, $urandom(), $urandom());
        else if (r < 43)
          send(cmd_t'(2'd3), $urandom(), $urandom());
        else
          send(CMD_LOOKUP, pick_key(), $urandom());
      end
    end

    // rebuild everything staged so far, then probe the table
    configure($urandom() | 1, 32'd10, 32'd0);
    send(CMD_BUILD, '0, '0);
    for (int k = 0; k < 40; k++) send(CMD_LOOKUP, pick_key(), $urandom());

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
